@@ rtl/lmms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmms_pkg
// Shared constants, codes and controller/datapath interface types for the
// latency median/min/max statistics block.
// ----------------------------------------------------------------------------
package lmms_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);

  localparam logic [31:0] THRESHOLD_RESET = 32'd16000000;
  localparam logic        FUNC_CLEAR      = 1'b1;

  // read address selects
  localparam logic [2:0] RA_POS1 = 3'd0;
  localparam logic [2:0] RA_POS2 = 3'd1;
  localparam logic [2:0] RA_ZERO = 3'd2;
  localparam logic [2:0] RA_LAST = 3'd3;
  localparam logic [2:0] RA_MIDH = 3'd4;
  localparam logic [2:0] RA_MIDL = 3'd5;

  // read data capture selects
  localparam logic [2:0] LAT_NONE = 3'd0;
  localparam logic [2:0] LAT_LO   = 3'd1;
  localparam logic [2:0] LAT_HI   = 3'd2;
  localparam logic [2:0] LAT_MA   = 3'd3;
  localparam logic [2:0] LAT_MB   = 3'd4;

  // write data selects
  localparam logic WD_SAMPLE = 1'b0;
  localparam logic WD_SHIFT  = 1'b1;

  typedef struct packed {
    logic       load_in;
    logic [2:0] rd_sel;
    logic       wr_en;
    logic       wr_sel;
    logic       pos_dec;
    logic       cnt_inc;
    logic       cnt_clr;
    logic       set_drop;
    logic [2:0] lat_sel;
    logic       calc_med;
    logic       load_out;
  } lmms_cmd_t;

  typedef struct packed {
    logic func_clr;
    logic full;
    logic cnt_zero;
    logic pos_zero;
    logic pos_one;
    logic gt;
    logic out_free;
  } lmms_stat_t;

endpackage

@@ rtl/lmms_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lmms_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmms_dp
// Datapath: sorted sample store, insertion pointer, count, statistics
// capture, median arithmetic, threshold register and output register.
// ----------------------------------------------------------------------------
module lmms_dp import lmms_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  lmms_cmd_t              cmd,
  output lmms_stat_t             stat,
  input  logic                   func,
  input  logic [SAMPLE_BITS-1:0] sample_ns,
  input  logic                   cfg_wr_en,
  input  logic [31:0]            cfg_wr_data,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [CNT_W-1:0]       sample_count,
  output logic [31:0]            median_ns,
  output logic [31:0]            min_ns,
  output logic [31:0]            max_ns,
  output logic                   pass,
  output logic                   dropped
);

  logic                   func_reg;
  logic [SAMPLE_BITS-1:0] sample;
  logic [CNT_W-1:0]       pos;
  logic [CNT_W-1:0]       cnt;
  logic                   drop;
  logic [31:0]            threshold;
  logic [SAMPLE_BITS-1:0] lo, hi, mid_a, mid_b, med;
  logic [SAMPLE_BITS:0]   mid_sum;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;
  logic [CNT_W-1:0]       half;

  assign half = cnt >> 1;

  always_comb begin
    case (cmd.rd_sel)
      RA_POS1: ram_raddr = ADDR_W'(pos - CNT_W'(1));
      RA_POS2: ram_raddr = ADDR_W'(pos - CNT_W'(2));
      RA_ZERO: ram_raddr = '0;
      RA_LAST: ram_raddr = ADDR_W'(cnt - CNT_W'(1));
      RA_MIDH: ram_raddr = ADDR_W'(half);
      RA_MIDL: ram_raddr = ADDR_W'(half - CNT_W'(1));
      default: ram_raddr = '0;
    endcase
  end

  assign ram_we    = cmd.wr_en;
  assign ram_waddr = pos[ADDR_W-1:0];
  assign ram_wdata = (cmd.wr_sel == WD_SHIFT) ? ram_rdata : sample;

  lmms_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      threshold <= THRESHOLD_RESET;
    end else begin
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_reg <= func;
      sample   <= sample_ns;
      pos      <= cnt;
      drop     <= 1'b0;
    end else begin
      if (cmd.pos_dec) begin
        pos <= pos - CNT_W'(1);
      end
      if (cmd.set_drop) begin
        drop <= 1'b1;
      end
    end
    case (cmd.lat_sel)
      LAT_LO:  lo    <= ram_rdata;
      LAT_HI:  hi    <= ram_rdata;
      LAT_MA:  mid_a <= ram_rdata;
      LAT_MB:  mid_b <= ram_rdata;
      default: ;
    endcase
    if (cmd.calc_med) begin
      med <= cnt[0] ? mid_a : mid_sum[SAMPLE_BITS:1];
    end
  end

  assign mid_sum = {1'b0, mid_a} + {1'b0, mid_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sample_count <= cnt;
      dropped      <= drop;
      if (cnt == '0) begin
        median_ns <= '0;
        min_ns    <= '0;
        max_ns    <= '0;
        pass      <= 1'b0;
      end else begin
        median_ns <= med;
        min_ns    <= lo;
        max_ns    <= hi;
        pass      <= (med < threshold);
      end
    end
  end

  assign stat.func_clr = (func_reg == FUNC_CLEAR);
  assign stat.full     = (cnt >= CNT_W'(MAX_SAMPLES));
  assign stat.cnt_zero = (cnt == '0);
  assign stat.pos_zero = (pos == '0);
  assign stat.pos_one  = (pos == CNT_W'(1));
  assign stat.gt       = (ram_rdata > sample);
  assign stat.out_free = !out_valid || !out_stall;

endmodule

@@ rtl/lmms_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmms_ctrl
// Controller: sequences accept, sorted insertion, statistics reads and the
// output load.
// ----------------------------------------------------------------------------
module lmms_ctrl import lmms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  lmms_stat_t stat,
  output lmms_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECIDE = 4'd1;
  localparam logic [3:0] ST_INS    = 4'd2;
  localparam logic [3:0] ST_CMP    = 4'd3;
  localparam logic [3:0] ST_RLO    = 4'd4;
  localparam logic [3:0] ST_RHI    = 4'd5;
  localparam logic [3:0] ST_RMA    = 4'd6;
  localparam logic [3:0] ST_RMB    = 4'd7;
  localparam logic [3:0] ST_LMB    = 4'd8;
  localparam logic [3:0] ST_MED    = 4'd9;
  localparam logic [3:0] ST_OUT    = 4'd10;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RA_ZERO;
    cmd.wr_sel = WD_SAMPLE;
    cmd.lat_sel = LAT_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.func_clr) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_RLO;
        end else if (stat.full) begin
          cmd.set_drop = 1'b1;
          state_next   = ST_RLO;
        end else begin
          state_next = ST_INS;
        end
      end
      ST_INS: begin
        if (stat.pos_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = ST_RLO;
        end else begin
          cmd.rd_sel = RA_POS1;
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (stat.gt) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WD_SHIFT;
          cmd.pos_dec = 1'b1;
          if (stat.pos_one) begin
            state_next = ST_INS;
          end else begin
            cmd.rd_sel = RA_POS2;
          end
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = ST_RLO;
        end
      end
      ST_RLO: begin
        if (stat.cnt_zero) begin
          state_next = ST_OUT;
        end else begin
          cmd.rd_sel = RA_ZERO;
          state_next = ST_RHI;
        end
      end
      ST_RHI: begin
        cmd.rd_sel  = RA_LAST;
        cmd.lat_sel = LAT_LO;
        state_next  = ST_RMA;
      end
      ST_RMA: begin
        cmd.rd_sel  = RA_MIDH;
        cmd.lat_sel = LAT_HI;
        state_next  = ST_RMB;
      end
      ST_RMB: begin
        cmd.rd_sel  = RA_MIDL;
        cmd.lat_sel = LAT_MA;
        state_next  = ST_LMB;
      end
      ST_LMB: begin
        cmd.lat_sel = LAT_MB;
        state_next  = ST_MED;
      end
      ST_MED: begin
        cmd.calc_med = 1'b1;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/latency_median_min_max_stats.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_median_min_max_stats
// Running count, minimum, maximum and median of up to 64 latency samples,
// held sorted in a RAM, with a threshold pass flag.
// Sequence: a clear empties the store and loads an empty result; a dropped
//   record reads min, max and median and loads them; a record is first
//   inserted, shifting k stored entries (k up to 63), one entry shift per
//   cycle, then read out the same way. The input stalls until the result
//   is loaded, which waits while the last result is stalled.
// Reset: synchronous, clears the count and control, threshold to 16000000.
// ----------------------------------------------------------------------------
module latency_median_min_max_stats import lmms_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [31:0]            cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   func,
  input  logic [SAMPLE_BITS-1:0] sample_ns,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CNT_W-1:0]       sample_count,
  output logic [31:0]            median_ns,
  output logic [31:0]            min_ns,
  output logic [31:0]            max_ns,
  output logic                   pass,
  output logic                   dropped
);

  lmms_cmd_t  cmd;
  lmms_stat_t stat;

  lmms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lmms_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (func),
    .sample_ns    (sample_ns),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .sample_count (sample_count),
    .median_ns    (median_ns),
    .min_ns       (min_ns),
    .max_ns       (max_ns),
    .pass         (pass),
    .dropped      (dropped)
  );

endmodule

@@ rtl/lmms_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmms_checker
// Port-level checks on result beats of the statistics block.
// ----------------------------------------------------------------------------
module lmms_checker import lmms_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [CNT_W-1:0]       sample_count,
  input logic [31:0]            median_ns,
  input logic [31:0]            min_ns,
  input logic [31:0]            max_ns,
  input logic                   pass,
  input logic                   dropped
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_count) && $stable(median_ns))
    else $error("stalled result beat changed");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample_count <= CNT_W'(MAX_SAMPLES))
    else $error("sample count above store depth");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_count == '0 |->
      median_ns == '0 && min_ns == '0 && max_ns == '0 && !pass)
    else $error("empty set gave nonzero statistics");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_count != '0 |-> min_ns <= median_ns && median_ns <= max_ns)
    else $error("median outside min and max");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> sample_count == CNT_W'(MAX_SAMPLES))
    else $error("drop flagged with store not full");

endmodule

bind latency_median_min_max_stats lmms_checker u_lmms_checker (.*);

@@ bench/latency_median_min_max_stats_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_median_min_max_stats_tb
// Self-checking bench for the running latency statistics block. A sorted
// sample store inside a scoreboard class predicts count, median, minimum,
// maximum, pass and drop for every input beat. Sample runs are mostly
// record sequences ended by a clear, some long enough to fill the store
// and force drops. The threshold changes between phases while the block is
// idle. Both channels idle at random, and the receiver holds off once for a
// long stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module latency_median_min_max_stats_tb;
  import lmms_pkg::*;

  localparam logic FUNC_RECORD    = 1'b0;
  localparam int   CLK_HALF       = 6;
  localparam int   RESET_CYCLES   = 5;
  localparam int   SETTLE_CYCLES  = 100;
  localparam int   SQUEEZE_CYCLES = 600;
  localparam int   WATCHDOG_LIMIT = 5000;
  localparam int   PHASE_ITEMS    = 140;
  localparam int   REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [31:0]      median;
    logic [31:0]      lo;
    logic [31:0]      hi;
    logic             pass;
    logic             dropped;
  } stats_t;

  class running_stats;
    logic [SAMPLE_BITS-1:0] held [MAX_SAMPLES];
    int unsigned            n_held;
    logic [31:0]            thr;
    stats_t                 stats_due [$];
    int unsigned            n_checked;
    int unsigned            n_bad;
    int unsigned            n_drops;
    int unsigned            n_clears;
    int unsigned            n_pass;

    function new();
      n_held    = 0;
      thr       = THRESHOLD_RESET;
      n_checked = 0;
      n_bad     = 0;
      n_drops   = 0;
      n_clears  = 0;
      n_pass    = 0;
    endfunction

    function void take_sample_beat(logic f, logic [SAMPLE_BITS-1:0] s);
      stats_t               e;
      int unsigned          pos;
      logic [SAMPLE_BITS:0] pair;
      e = '0;
      if (f == FUNC_CLEAR) begin
        n_held = 0;
        n_clears++;
      end else if (n_held >= MAX_SAMPLES) begin
        e.dropped = 1'b1;
        n_drops++;
      end else begin
        // equal samples go after the ones already held
        pos = n_held;
        while (pos > 0 && held[pos-1] > s) begin
          held[pos] = held[pos-1];
          pos--;
        end
        held[pos] = s;
        n_held++;
      end
      if (n_held > 0) begin
        if (n_held % 2 != 0) begin
          e.median = held[n_held/2];
        end else begin
          pair     = {1'b0, held[n_held/2-1]} + {1'b0, held[n_held/2]};
          e.median = pair[SAMPLE_BITS:1];
        end
        e.lo   = held[0];
        e.hi   = held[n_held-1];
        e.pass = (e.median < thr);
        if (e.pass) n_pass++;
      end
      e.count = n_held[CNT_W-1:0];
      stats_due = {stats_due, e};
    endfunction

    function void check_stats_beat(stats_t got);
      stats_t e;
      n_checked++;
      if (stats_due.size() == 0) begin
        n_bad++;
        if (n_bad <= REPORT_LIMIT)
          $display("stats beat %0d with nothing due: cnt=%0d med=%h min=%h max=%h p=%b d=%b",
                   n_checked, got.count, got.median, got.lo, got.hi, got.pass, got.dropped);
        return;
      end
      e = stats_due.pop_front();
      if (got.count !== e.count || got.median !== e.median || got.lo !== e.lo ||
          got.hi !== e.hi || got.pass !== e.pass || got.dropped !== e.dropped) begin
        n_bad++;
        if (n_bad <= REPORT_LIMIT) begin
          $display("stats beat %0d differs", n_checked);
          $display("  want cnt=%0d med=%h min=%h max=%h p=%b d=%b",
                   e.count, e.median, e.lo, e.hi, e.pass, e.dropped);
          $display("  got  cnt=%0d med=%h min=%h max=%h p=%b d=%b",
                   got.count, got.median, got.lo, got.hi, got.pass, got.dropped);
        end
      end
    endfunction

    function int unsigned pending();
      return stats_due.size();
    endfunction
  endclass

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   cfg_wr_en   = 1'b0;
  logic [31:0]            cfg_wr_data = '0;
  logic                   in_valid    = 1'b0;
  logic                   in_stall;
  logic                   func        = 1'b0;
  logic [SAMPLE_BITS-1:0] sample_ns   = '0;
  logic                   out_valid;
  logic                   out_stall   = 1'b0;
  logic [CNT_W-1:0]       sample_count;
  logic [31:0]            median_ns;
  logic [31:0]            min_ns;
  logic [31:0]            max_ns;
  logic                   pass;
  logic                   dropped;

  running_stats board = new();
  bit           tx_jitter   = 1'b1;
  bit           rx_jitter   = 1'b1;
  bit           squeeze_req = 1'b0;
  int unsigned  beats_in    = 0;
  int unsigned  n_settings  = 1;
  int unsigned  idle_cycles = 0;

  latency_median_min_max_stats dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .sample_ns    (sample_ns),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_count (sample_count),
    .median_ns    (median_ns),
    .min_ns       (min_ns),
    .max_ns       (max_ns),
    .pass         (pass),
    .dropped      (dropped)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int pick_gap(bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(logic [SAMPLE_BITS-1:0] last_s);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 15);
      3:       return board.thr + $urandom_range(0, 6) - 3;
      4:       return last_s;
      5:       return ~($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // result side: random hold-offs, one long squeeze on request
  initial begin : rx_side
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else begin
        gap = pick_gap(rx_jitter);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_stats_beat('{sample_count, median_ns, min_ns, max_ns, pass, dropped});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, board.pending());
      $display("latency_median_min_max_stats: mismatch");
      $finish;
    end
  end

  task automatic send_item(input logic f, input logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = pick_gap(tx_jitter);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    sample_ns <= s;
    do @(posedge clk); while (in_stall);
    board.take_sample_beat(f, s);
    beats_in++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.thr = v;
    n_settings++;
  endtask

  task automatic run_random(input int n_items, input bit fill_first);
    int                     left;
    int                     run_len;
    int                     r;
    int                     k;
    bit                     first;
    logic [SAMPLE_BITS-1:0] last_s;
    logic [SAMPLE_BITS-1:0] s;
    left   = n_items;
    last_s = '0;
    first  = fill_first;
    if (fill_first) begin
      send_item(FUNC_CLEAR, $urandom);
      left--;
    end
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (first || r >= 92) run_len = $urandom_range(MAX_SAMPLES, MAX_SAMPLES + 8);
      else if (r < 70)      run_len = $urandom_range(1, 16);
      else                  run_len = $urandom_range(17, MAX_SAMPLES - 1);
      first = 1'b0;
      for (k = 0; k < run_len && left > 0; k++) begin
        if ($urandom_range(0, 99) < 3) begin
          send_item(FUNC_CLEAR, $urandom);
        end else begin
          s = pick_sample(last_s);
          send_item(FUNC_RECORD, s);
          last_s = s;
        end
        left--;
      end
      if (left > 0) begin
        send_item(FUNC_CLEAR, $urandom);
        left--;
      end
    end
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty set, extremes, carry in the even median, threshold edge
    send_item(FUNC_CLEAR,  32'hFFFF_FFFF);
    send_item(FUNC_RECORD, 32'h0000_0000);
    send_item(FUNC_RECORD, 32'hFFFF_FFFF);
    send_item(FUNC_RECORD, 32'hFFFF_FFFF);
    send_item(FUNC_RECORD, 32'hFFFF_FFFE);
    send_item(FUNC_CLEAR,  32'h0000_0000);
    send_item(FUNC_RECORD, THRESHOLD_RESET);
    send_item(FUNC_RECORD, THRESHOLD_RESET - 1);
    send_item(FUNC_RECORD, THRESHOLD_RESET - 1);
    send_item(FUNC_RECORD, THRESHOLD_RESET + 1);
    send_item(FUNC_CLEAR,  32'h5555_5555);
    send_item(FUNC_RECORD, 32'hAAAA_AAAA);
    send_item(FUNC_RECORD, 32'h5555_5555);
    send_item(FUNC_RECORD, 32'h1234_5678);
    send_item(FUNC_RECORD, 32'h0000_0001);
    send_item(FUNC_RECORD, 32'h8000_0000);
    send_item(FUNC_CLEAR,  32'hAAAA_AAAA);
    send_item(FUNC_CLEAR,  32'h0000_0000);
    send_item(FUNC_RECORD, 32'h7FFF_FFFF);
    send_item(FUNC_RECORD, 32'h8000_0000);
    drain();

    write_threshold(32'h0000_0000);
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    run_random(PHASE_ITEMS, 1'b1);
    drain();

    write_threshold(32'hFFFF_FFFF);
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    run_random(PHASE_ITEMS, 1'b0);
    drain();

    write_threshold($urandom);
    tx_jitter   = 1'b0;
    rx_jitter   = 1'b1;
    squeeze_req = 1'b1;
    run_random(PHASE_ITEMS, 1'b1);
    drain();

    write_threshold(THRESHOLD_RESET);
    tx_jitter = 1'b1;
    rx_jitter = 1'b0;
    run_random(PHASE_ITEMS, 1'b0);
    drain();

    write_threshold(32'h0000_0001);
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    run_random(PHASE_ITEMS, 1'b1);
    drain();

    board.n_bad += board.pending();
    $display("covered %0d input beats over %0d threshold settings: %0d results checked",
             beats_in, n_settings, board.n_checked);
    $display("  %0d clears, %0d dropped records, %0d passing results, %0d mismatches",
             board.n_clears, board.n_drops, board.n_pass, board.n_bad);
    if (board.n_bad == 0) begin
      $display("latency_median_min_max_stats: match");
    end else begin
      $display("latency_median_min_max_stats: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lmms_pkg.sv
rtl/lmms_ram.sv
rtl/lmms_dp.sv
rtl/lmms_ctrl.sv
rtl/latency_median_min_max_stats.sv
rtl/lmms_checker.sv
bench/latency_median_min_max_stats_tb.sv
